>>> design/piecewise_linear_interpolator_core_assert.svh
// ----------------------------------------------------------------------------
// piecewise_linear_interpolator_core assertion macros
// Shorthand for clocked, reset-qualified concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef PIECEWISE_LINEAR_INTERPOLATOR_CORE_ASSERT_SVH
`define PIECEWISE_LINEAR_INTERPOLATOR_CORE_ASSERT_SVH

// same-cycle implication
`define PLI_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PLI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/pli_pkg.sv
// ----------------------------------------------------------------------------
// pli_pkg
// Shared widths, codes and beat types of the piecewise linear interpolator.
// ----------------------------------------------------------------------------
package pli_pkg;

  localparam int DATA_W      = 32;
  localparam int FRAC_BITS   = 16;
  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int CFG_W       = 7;
  localparam int ENTRY_W     = 6;

  // segment arithmetic
  localparam int DIFF_W      = DATA_W + 1;             // exact difference
  localparam int QUO_W       = DIFF_W + FRAC_BITS;     // t magnitude
  localparam int DIV_CNT_W   = $clog2(QUO_W + 1);
  localparam int MCH_W       = 17;                     // multiplier chunk
  localparam int MCH_N       = (QUO_W + MCH_W - 1) / MCH_W;
  localparam int MA_W        = MCH_N * MCH_W;
  localparam int MUL_CNT_W   = $clog2(MCH_N + 1);
  localparam int PROD_W      = QUO_W + DIFF_W;
  localparam int Q_W         = PROD_W - FRAC_BITS;
  localparam int SAT_LIM_BIT = 40;
  localparam int SUM_W       = SAT_LIM_BIT + 3;

  localparam logic [Q_W-1:0]    SAT_LIM = Q_W'(1) << SAT_LIM_BIT;
  localparam logic [DATA_W-1:0] Y_MAX   = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] Y_MIN   = {1'b1, {(DATA_W-1){1'b0}}};

  typedef enum logic {
    FUNC_LOAD  = 1'b0,
    FUNC_QUERY = 1'b1
  } func_t;

  typedef struct packed {
    func_t                     func;
    logic [ENTRY_W-1:0]        entry_index;
    logic signed [DATA_W-1:0]  x_value;
    logic signed [DATA_W-1:0]  y_value;
    logic                      final_query;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0]  y_result;
    logic                      saturated;
    logic                      final_result;
  } out_item_t;

  typedef struct packed {
    logic                en;
    logic [IDX_W-1:0]    addr;
    logic [DATA_W-1:0]   x;
    logic [DATA_W-1:0]   y;
  } tbl_wr_t;

endpackage

>>> design/piecewise_linear_interpolator_core.sv
// ----------------------------------------------------------------------------
// piecewise_linear_interpolator_core
// 1-D piecewise linear interpolation over a loaded breakpoint table, Q16.16.
// ----------------------------------------------------------------------------
//  channel  | ports                   | beat
//  ---------+-------------------------+---------------------------------------
//  in       | in_valid/in_ready       | in_item_t: load or query
//  out      | out_valid/out_ready     | out_item_t: one per query
//  cfg      | cfg_we/cfg_wdata        | points_in_use, no wait, no read-back
//
//  A load beat is written at the edge that accepts it. A query keeps in_ready
//  low while it checks the end breakpoints, scans for the bracketing pair,
//  reads both ends, waits on the bit-serial divider and chunked multiplier,
//  saturates and emits. Reset clears control state only; table entries are
//  undefined until loaded. A waiting result stalls only the next query's emit
//  state; new beats are accepted while it waits.
// ----------------------------------------------------------------------------
`include "piecewise_linear_interpolator_core_assert.svh"

module piecewise_linear_interpolator_core (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  pli_pkg::in_item_t          in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output pli_pkg::out_item_t         out_data,
  input  logic                       cfg_we,
  input  logic [pli_pkg::CFG_W-1:0]  cfg_wdata
);
  import pli_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE = 11'b000_0000_0001,
    S_CHK0 = 11'b000_0000_0010,
    S_CHKL = 11'b000_0000_0100,
    S_SCAN = 11'b000_0000_1000,
    S_FA   = 11'b000_0001_0000,
    S_FB   = 11'b000_0010_0000,
    S_PREP = 11'b000_0100_0000,
    S_DIV  = 11'b000_1000_0000,
    S_MUL  = 11'b001_0000_0000,
    S_SAT  = 11'b010_0000_0000,
    S_EMIT = 11'b100_0000_0000
  } state_t;

  state_t                   state_r, state_nxt;
  logic [CFG_W-1:0]         cfg_r;
  logic [CNT_W-1:0]         n_eff;
  logic [CNT_W-1:0]         n_r, n_nxt;
  logic signed [DATA_W-1:0] x_r, x_nxt;
  logic                     fin_r, fin_nxt;
  logic [IDX_W-1:0]         k_r, k_nxt;
  logic [IDX_W-1:0]         seg_r, seg_nxt;
  logic signed [DATA_W-1:0] prev_x_r, prev_x_nxt;
  logic signed [DATA_W-1:0] x0_r, x0_nxt;
  logic signed [DATA_W-1:0] y0_r, y0_nxt;
  logic signed [DIFF_W-1:0] dx_r, dx_nxt;
  logic signed [DIFF_W-1:0] w_r, w_nxt;
  logic signed [DIFF_W-1:0] dy_r, dy_nxt;
  logic                     neg_r, neg_nxt;
  logic [DIFF_W-1:0]        ady_r, ady_nxt;
  logic signed [SUM_W-1:0]  sum_r, sum_nxt;
  logic                     over_r, over_nxt;
  logic [DATA_W-1:0]        res_y_r, res_y_nxt;
  logic                     res_sat_r, res_sat_nxt;
  logic                     out_valid_r, out_valid_nxt;
  out_item_t                out_data_r;
  logic                     out_load;

  tbl_wr_t                  wr;
  logic                     rd_en;
  logic [IDX_W-1:0]         rd_addr;
  logic [DATA_W-1:0]        rd_x, rd_y;
  logic signed [DATA_W-1:0] rd_xs, rd_ys;
  logic [IDX_W-1:0]         last_idx, seg_last;

  logic                     div_start, div_done;
  logic [QUO_W-1:0]         div_quo;
  logic [DIFF_W-1:0]        dx_mag, w_mag;
  logic                     mul_done;
  logic [PROD_W-1:0]        mul_prod;
  logic [Q_W-1:0]           q;
  logic signed [SUM_W-1:0]  q_ext, y0_ext;

  assign in_ready = (state_r == S_IDLE);
  assign rd_xs    = $signed(rd_x);
  assign rd_ys    = $signed(rd_y);
  assign last_idx = IDX_W'(n_r - CNT_W'(1));
  assign seg_last = IDX_W'(n_r - CNT_W'(2));

  always_comb begin
    if (cfg_r == '0) begin
      n_eff = CNT_W'(1);
    end else if (32'(cfg_r) > TABLE_DEPTH) begin
      n_eff = CNT_W'(TABLE_DEPTH);
    end else begin
      n_eff = CNT_W'(cfg_r);
    end
  end

  // loads go straight to the memory at the accepting edge
  always_comb begin
    wr.en   = in_valid && in_ready && (in_data.func == FUNC_LOAD) &&
              (32'(in_data.entry_index) < TABLE_DEPTH);
    wr.addr = IDX_W'(in_data.entry_index);
    wr.x    = in_data.x_value;
    wr.y    = in_data.y_value;
  end

  pli_table u_table (
    .clk     (clk),
    .wr      (wr),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_x    (rd_x),
    .rd_y    (rd_y)
  );

  assign dx_mag = dx_r[DIFF_W-1] ? DIFF_W'(-dx_r) : DIFF_W'(dx_r);
  assign w_mag  = w_r[DIFF_W-1]  ? DIFF_W'(-w_r)  : DIFF_W'(w_r);

  pli_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend ({dx_mag, {FRAC_BITS{1'b0}}}),
    .divisor  (w_mag),
    .done     (div_done),
    .quotient (div_quo)
  );

  pli_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_done),
    .a     (div_quo),
    .b     (ady_r),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  assign q      = mul_prod[PROD_W-1:FRAC_BITS];
  assign q_ext  = $signed({{(SUM_W-SAT_LIM_BIT-1){1'b0}}, q[SAT_LIM_BIT:0]});
  assign y0_ext = SUM_W'(y0_r);

  always_comb begin
    state_nxt   = state_r;
    n_nxt       = n_r;
    x_nxt       = x_r;
    fin_nxt     = fin_r;
    k_nxt       = k_r;
    seg_nxt     = seg_r;
    prev_x_nxt  = prev_x_r;
    x0_nxt      = x0_r;
    y0_nxt      = y0_r;
    dx_nxt      = dx_r;
    w_nxt       = w_r;
    dy_nxt      = dy_r;
    neg_nxt     = neg_r;
    ady_nxt     = ady_r;
    sum_nxt     = sum_r;
    over_nxt    = over_r;
    res_y_nxt   = res_y_r;
    res_sat_nxt = res_sat_r;
    rd_en       = 1'b0;
    rd_addr     = '0;
    div_start   = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && in_data.func == FUNC_QUERY) begin
          x_nxt     = in_data.x_value;
          fin_nxt   = in_data.final_query;
          n_nxt     = n_eff;
          rd_en     = 1'b1;
          rd_addr   = '0;
          state_nxt = S_CHK0;
        end
      end
      S_CHK0: begin
        prev_x_nxt = rd_xs;
        if (n_r == CNT_W'(1)) begin
          res_y_nxt   = rd_y;
          res_sat_nxt = 1'b0;
          state_nxt   = S_EMIT;
        end else if (x_r <= rd_xs) begin
          seg_nxt   = '0;
          rd_en     = 1'b1;
          rd_addr   = '0;
          state_nxt = S_FA;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = last_idx;
          state_nxt = S_CHKL;
        end
      end
      S_CHKL: begin
        if (rd_xs <= x_r) begin
          seg_nxt   = seg_last;
          rd_en     = 1'b1;
          rd_addr   = seg_last;
          state_nxt = S_FA;
        end else begin
          k_nxt     = IDX_W'(1);
          rd_en     = 1'b1;
          rd_addr   = IDX_W'(1);
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (prev_x_r <= x_r && x_r <= rd_xs) begin
          seg_nxt   = k_r - IDX_W'(1);
          rd_en     = 1'b1;
          rd_addr   = k_r - IDX_W'(1);
          state_nxt = S_FA;
        end else if (k_r == last_idx) begin
          // non-ascending table, nothing brackets x
          seg_nxt   = seg_last;
          rd_en     = 1'b1;
          rd_addr   = seg_last;
          state_nxt = S_FA;
        end else begin
          prev_x_nxt = rd_xs;
          k_nxt      = k_r + IDX_W'(1);
          rd_en      = 1'b1;
          rd_addr    = k_r + IDX_W'(1);
        end
      end
      S_FA: begin
        x0_nxt    = rd_xs;
        y0_nxt    = rd_ys;
        rd_en     = 1'b1;
        rd_addr   = seg_r + IDX_W'(1);
        state_nxt = S_FB;
      end
      S_FB: begin
        dx_nxt    = DIFF_W'(x_r) - DIFF_W'(x0_r);
        w_nxt     = DIFF_W'(rd_xs) - DIFF_W'(x0_r);
        dy_nxt    = DIFF_W'(rd_ys) - DIFF_W'(y0_r);
        state_nxt = S_PREP;
      end
      S_PREP: begin
        neg_nxt = dx_r[DIFF_W-1] ^ w_r[DIFF_W-1] ^ dy_r[DIFF_W-1];
        ady_nxt = dy_r[DIFF_W-1] ? DIFF_W'(-dy_r) : DIFF_W'(dy_r);
        if (w_r == '0) begin
          // zero-width segment: left y
          res_y_nxt   = y0_r;
          res_sat_nxt = 1'b0;
          state_nxt   = S_EMIT;
        end else begin
          div_start = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        if (mul_done) begin
          over_nxt  = (q > SAT_LIM);
          sum_nxt   = neg_r ? (y0_ext - q_ext) : (y0_ext + q_ext);
          state_nxt = S_SAT;
        end
      end
      S_SAT: begin
        if (over_r) begin
          res_y_nxt   = neg_r ? Y_MIN : Y_MAX;
          res_sat_nxt = 1'b1;
        end else if (sum_r[SUM_W-1:DATA_W-1] != '0 &&
                     sum_r[SUM_W-1:DATA_W-1] != '1) begin
          res_y_nxt   = sum_r[SUM_W-1] ? Y_MIN : Y_MAX;
          res_sat_nxt = 1'b1;
        end else begin
          res_y_nxt   = sum_r[DATA_W-1:0];
          res_sat_nxt = 1'b0;
        end
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_load      = (state_r == S_EMIT) && (!out_valid_r || out_ready);
  assign out_valid_nxt = out_load || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      cfg_r       <= CFG_W'(1);
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        cfg_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    n_r       <= n_nxt;
    x_r       <= x_nxt;
    fin_r     <= fin_nxt;
    k_r       <= k_nxt;
    seg_r     <= seg_nxt;
    prev_x_r  <= prev_x_nxt;
    x0_r      <= x0_nxt;
    y0_r      <= y0_nxt;
    dx_r      <= dx_nxt;
    w_r       <= w_nxt;
    dy_r      <= dy_nxt;
    neg_r     <= neg_nxt;
    ady_r     <= ady_nxt;
    sum_r     <= sum_nxt;
    over_r    <= over_nxt;
    res_y_r   <= res_y_nxt;
    res_sat_r <= res_sat_nxt;
    if (out_load) begin
      out_data_r.y_result     <= $signed(res_y_r);
      out_data_r.saturated    <= res_sat_r;
      out_data_r.final_result <= fin_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `PLI_ASSERT_NOW(a_rd_in_use, rd_en && state_r != S_IDLE, CNT_W'(rd_addr) < n_r,
                  "table read beyond points in use")
  `PLI_ASSERT_NOW(a_scan_range, state_r == S_SCAN, k_r != '0 && CNT_W'(k_r) < n_r,
                  "scan index out of range")
  `PLI_ASSERT_NOW(a_div_owner, div_done, state_r == S_DIV,
                  "divider finished outside divide wait")
  `PLI_ASSERT_NOW(a_mul_owner, mul_done, state_r == S_MUL,
                  "multiplier finished outside multiply wait")

endmodule

>>> design/pli_table.sv
// ----------------------------------------------------------------------------
// pli_table
// Breakpoint store: x and y arrays, one write and one registered read port.
// ----------------------------------------------------------------------------
module pli_table (
  input  logic                       clk,
  input  pli_pkg::tbl_wr_t           wr,
  input  logic                       rd_en,
  input  logic [pli_pkg::IDX_W-1:0]  rd_addr,
  output logic [pli_pkg::DATA_W-1:0] rd_x,
  output logic [pli_pkg::DATA_W-1:0] rd_y
);
  import pli_pkg::*;

  logic [DATA_W-1:0] mem_x [TABLE_DEPTH];
  logic [DATA_W-1:0] mem_y [TABLE_DEPTH];
  logic [DATA_W-1:0] rd_x_r;
  logic [DATA_W-1:0] rd_y_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem_x[wr.addr] <= wr.x;
      mem_y[wr.addr] <= wr.y;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_x_r <= mem_x[rd_addr];
      rd_y_r <= mem_y[rd_addr];
    end
  end

  assign rd_x = rd_x_r;
  assign rd_y = rd_y_r;

endmodule

>>> design/pli_div.sv
// ----------------------------------------------------------------------------
// pli_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pli_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [pli_pkg::QUO_W-1:0]   dividend,
  input  logic [pli_pkg::DIFF_W-1:0]  divisor,
  output logic                        done,
  output logic [pli_pkg::QUO_W-1:0]   quotient
);
  import pli_pkg::*;

  logic [DIFF_W-1:0]    rem_r;
  logic [QUO_W-1:0]     quo_r;
  logic [DIFF_W-1:0]    dvs_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 busy_r;
  logic                 done_r;
  logic [DIFF_W:0]      sh;
  logic [DIFF_W:0]      diff;
  logic                 ge;

  assign sh   = {rem_r, quo_r[QUO_W-1]};
  assign ge   = (sh >= {1'b0, dvs_r});
  assign diff = sh - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == DIV_CNT_W'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
      cnt_r <= DIV_CNT_W'(QUO_W);
    end else if (busy_r) begin
      rem_r <= ge ? diff[DIFF_W-1:0] : sh[DIFF_W-1:0];
      quo_r <= {quo_r[QUO_W-2:0], ge};
      cnt_r <= cnt_r - DIV_CNT_W'(1);
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

>>> design/pli_mul.sv
// ----------------------------------------------------------------------------
// pli_mul
// Unsigned multiplier, one MCH_W-bit chunk of the wide operand per cycle.
// ----------------------------------------------------------------------------
module pli_mul (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [pli_pkg::QUO_W-1:0]   a,
  input  logic [pli_pkg::DIFF_W-1:0]  b,
  output logic                        done,
  output logic [pli_pkg::PROD_W-1:0]  prod
);
  import pli_pkg::*;

  logic [MA_W-1:0]         a_r;
  logic [DIFF_W-1:0]       b_r;
  logic [PROD_W-1:0]       acc_r;
  logic [MUL_CNT_W-1:0]    cnt_r;
  logic                    busy_r;
  logic                    done_r;
  logic [MCH_W+DIFF_W-1:0] pp;

  // top chunk first, accumulator shifts up
  assign pp = a_r[MA_W-1 -: MCH_W] * b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == MUL_CNT_W'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= MA_W'(a);
      b_r   <= b;
      acc_r <= '0;
      cnt_r <= MUL_CNT_W'(MCH_N);
    end else if (busy_r) begin
      a_r   <= a_r << MCH_W;
      acc_r <= (acc_r << MCH_W) + PROD_W'(pp);
      cnt_r <= cnt_r - MUL_CNT_W'(1);
    end
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for piecewise_linear_interpolator_core. Loads breakpoint
// tables, sends query beats with random idling on both channels, and checks
// every result beat against an in-bench interpolation predictor.
// ----------------------------------------------------------------------------
module tb_top;
  import pli_pkg::*;

  localparam int     CYCLE_LIMIT   = 1_500_000;
  localparam int     SETTLE_CYCLES = 200;
  localparam int     RANDOM_PHASES = 8;
  localparam int     PHASE_BEATS   = 215;
  localparam int     IDLE_PCT      = 17;
  localparam longint Y_HI          = 64'sd2147483647;
  localparam longint Y_LO          = -64'sd2147483648;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  in_item_t           in_data;
  logic               out_valid;
  logic               out_ready;
  out_item_t          out_data;
  logic               cfg_we;
  logic [CFG_W-1:0]   cfg_wdata;

  // predictor state
  logic signed [DATA_W-1:0] bp_x [TABLE_DEPTH];
  logic signed [DATA_W-1:0] bp_y [TABLE_DEPTH];
  logic [CFG_W-1:0]         points_cfg;
  out_item_t                pending_y[$];

  int error_count;
  int beat_count;
  int load_count;
  int query_count;
  int checked_count;
  int sat_count;
  int cycle_count;
  bit calm;

  piecewise_linear_interpolator_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results still pending", $time, pending_y.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic bit take_break();
    return !calm && ($urandom_range(0, 99) < IDLE_PCT);
  endfunction

  function automatic logic [DATA_W-1:0] clamp32(input longint v);
    if (v > Y_HI) return Y_MAX;
    if (v < Y_LO) return Y_MIN;
    return v[DATA_W-1:0];
  endfunction

  // out-of-range register values fold into 1..TABLE_DEPTH
  function automatic int points_used();
    if (points_cfg == 0) return 1;
    if (points_cfg > TABLE_DEPTH) return TABLE_DEPTH;
    return int'(points_cfg);
  endfunction

  function automatic out_item_t interpolate_y(input in_item_t beat);
    out_item_t          res;
    int                 n;
    int                 seg;
    int                 k;
    longint             qx, x0, y0, x1, y1, dx, w, dy, r;
    longint unsigned    tmag, ady;
    logic [127:0]       mq;
    bit                 neg;
    res.final_result = beat.final_query;
    res.saturated    = 1'b0;
    n = points_used();
    if (n == 1) begin
      res.y_result = bp_y[0];
      return res;
    end
    qx = longint'(beat.x_value);
    if (qx <= bp_x[0]) begin
      seg = 0;
    end else if (bp_x[n-1] <= qx) begin
      seg = n - 2;
    end else begin
      // unsorted tables with no bracketing pair fall back to the last segment
      seg = n - 2;
      for (k = 1; k < n; k++) begin
        if (bp_x[k-1] <= qx && qx <= bp_x[k]) begin
          seg = k - 1;
          break;
        end
      end
    end
    x0 = longint'(bp_x[seg]);
    y0 = longint'(bp_y[seg]);
    x1 = longint'(bp_x[seg+1]);
    y1 = longint'(bp_y[seg+1]);
    w  = x1 - x0;
    if (w == 0) begin
      res.y_result = y0[DATA_W-1:0];
      return res;
    end
    dx   = qx - x0;
    dy   = y1 - y0;
    tmag = ((dx < 0 ? -dx : dx) << FRAC_BITS) / (w < 0 ? -w : w);
    ady  = dy < 0 ? -dy : dy;
    neg  = ((dx < 0) != (w < 0)) != (dy < 0);
    mq   = (128'(tmag) * 128'(ady)) >> FRAC_BITS;
    if (mq > (128'(1) << SAT_LIM_BIT)) begin
      res.saturated = 1'b1;
      res.y_result  = neg ? Y_MIN : Y_MAX;
      return res;
    end
    r = neg ? y0 - longint'(mq[63:0]) : y0 + longint'(mq[63:0]);
    if (r > Y_HI || r < Y_LO) res.saturated = 1'b1;
    res.y_result = clamp32(r);
    return res;
  endfunction

  task automatic send_beat(input in_item_t beat);
    while (take_break()) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    beat_count++;
    if (beat.func == FUNC_LOAD) begin
      bp_x[beat.entry_index] = beat.x_value;
      bp_y[beat.entry_index] = beat.y_value;
      load_count++;
    end else begin
      pending_y.push_back(interpolate_y(beat));
      query_count++;
    end
  endtask

  task automatic load_point(input int idx, input logic [DATA_W-1:0] x,
                            input logic [DATA_W-1:0] y);
    in_item_t b;
    b.func        = FUNC_LOAD;
    b.entry_index = idx[ENTRY_W-1:0];
    b.x_value     = x;
    b.y_value     = y;
    b.final_query = 1'($urandom_range(0, 1));
    send_beat(b);
  endtask

  task automatic query_point(input logic [DATA_W-1:0] x, input logic fin);
    in_item_t b;
    b.func        = FUNC_QUERY;
    b.entry_index = ENTRY_W'($urandom_range(0, TABLE_DEPTH - 1));
    b.x_value     = x;
    b.y_value     = $urandom;
    b.final_query = fin;
    send_beat(b);
  endtask

  // drain results, then give a trailing load or query time to finish
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_y.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_points(input logic [CFG_W-1:0] val);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we     <= 1'b0;
    points_cfg  = val;
  endtask

  task automatic flag_mismatch(input string what, input logic [DATA_W-1:0] want_v,
                               input logic [DATA_W-1:0] got_v);
    error_count++;
    $display("%0t: %s mismatch: expected %h, actual %h", $time, what, want_v, got_v);
  endtask

  initial begin : result_check
    out_item_t want;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        if (pending_y.size() == 0) begin
          error_count++;
          $display("%0t: result beat with nothing pending: expected none, actual %h",
                   $time, out_data);
        end else begin
          want = pending_y.pop_front();
          checked_count++;
          if (want.saturated) sat_count++;
          if (out_data.y_result !== want.y_result)
            flag_mismatch("y_result", want.y_result, out_data.y_result);
          if (out_data.saturated !== want.saturated)
            flag_mismatch("saturated", DATA_W'(want.saturated),
                          DATA_W'(out_data.saturated));
          if (out_data.final_result !== want.final_result)
            flag_mismatch("final_result", DATA_W'(want.final_result),
                          DATA_W'(out_data.final_result));
        end
      end
      out_ready <= !take_break();
    end
  end

  // reset register value: a single breakpoint answers every query
  task automatic test_single_breakpoint();
    load_point(0, 32'sh0005_0000, Y_MIN);
    query_point(32'sh8000_0000, 1'b1);
    query_point(32'sh7FFF_FFFF, 1'b0);
  endtask

  task automatic test_zero_width();
    set_points(2);
    load_point(1, 32'sh0005_0000, 32'sh0007_0000);
    query_point(32'sh8000_0000, 1'b0);
    query_point(32'sh7FFF_FFFF, 1'b1);
    query_point(32'sh0005_0000, 1'b0);
    // zero in the register behaves as one point
    set_points(0);
    query_point(32'sh0000_0000, 1'b1);
  endtask

  task automatic test_segment_search();
    set_points(4);
    load_point(0, 32'shFFFC_0000, Y_MAX);
    load_point(1, 32'sh0000_0000, 32'sh0002_0000);
    load_point(2, 32'sh0001_0000, Y_MAX);
    load_point(3, 32'sh0003_0000, 32'shFFFF_0000);
    query_point(32'sh8000_0000, 1'b0);  // far below: clips high
    query_point(32'shFFFC_0000, 1'b0);
    query_point(32'shFFFE_0000, 1'b0);
    query_point(32'sh0000_0000, 1'b0);
    query_point(32'sh0000_8000, 1'b0);
    query_point(32'sh0001_0000, 1'b0);
    query_point(32'sh0002_0000, 1'b0);
    query_point(32'sh0003_0000, 1'b0);
    query_point(32'sh7FFF_FFFF, 1'b1);  // far above: clips low
  endtask

  task automatic test_unsorted_table();
    set_points(3);
    load_point(0, 32'sh0001_0000, 32'sh000A_0000);
    load_point(1, 32'shFFFE_0000, 32'shFFFD_0000);
    load_point(2, 32'sh0004_0000, 32'sh0008_0000);
    query_point(32'sh0000_0000, 1'b0);
    query_point(32'sh0003_0000, 1'b0);
    query_point(32'sh0005_0000, 1'b1);
  endtask

  task automatic fill_table(input int cnt);
    int     shape;
    int     k;
    int     r32;
    longint px, py, step_max, step;
    shape    = $urandom_range(0, 3);
    r32      = $urandom;
    px       = longint'(r32);
    r32      = $urandom;
    py       = longint'(r32);
    step_max = 4;
    unique case (shape)
      0: begin
        px       = Y_LO + longint'($urandom_range(0, 1 << 20));
        step_max = 64'sd4294967295 / cnt;
      end
      1: begin
        px       = px >>> 8;
        step_max = longint'(1 << 17);
      end
      default: ;
    endcase
    for (k = 0; k < cnt; k++) begin
      if (shape == 3) begin
        r32 = $urandom;
        px  = longint'(r32);
      end
      r32 = $urandom;
      if ($urandom_range(0, 1)) py = longint'(r32);
      else py = longint'($signed(clamp32(py + longint'(r32 >>> 12))));
      load_point(k, clamp32(px), clamp32(py));
      step = ($urandom_range(0, 7) == 0) ? 0 : longint'($urandom) % (step_max + 1);
      px   = px + step;
    end
  endtask

  task automatic random_query(input int n);
    longint lo, hi, qx;
    int     pick;
    int     r32;
    lo = longint'(bp_x[0]);
    hi = longint'(bp_x[n-1]);
    if (lo > hi) begin
      qx = lo;
      lo = hi;
      hi = qx;
    end
    pick = $urandom_range(0, 9);
    if (pick < 4) begin
      r32 = $urandom;
      qx  = longint'(r32);
    end else if (pick < 8) begin
      qx = lo - 65536 + longint'($urandom) % (hi - lo + 131073);
    end else begin
      qx = longint'(bp_x[$urandom_range(0, n - 1)]);
      qx = qx + longint'($urandom_range(0, 2)) - 1;
    end
    query_point(clamp32(qx), $urandom_range(0, 7) == 0);
  endtask

  task automatic test_random_tables();
    int               phase;
    int               n;
    int               start;
    logic [CFG_W-1:0] cfg_val;
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      unique case (phase)
        0:       cfg_val = CFG_W'(TABLE_DEPTH);       // first phase fills every slot
        1:       cfg_val = '1;
        2:       cfg_val = CFG_W'(TABLE_DEPTH + 1);
        3:       cfg_val = CFG_W'(2);
        default: cfg_val = CFG_W'($urandom_range(0, (1 << CFG_W) - 1));
      endcase
      set_points(cfg_val);
      calm  = (phase == 4);
      n     = points_used();
      start = beat_count;
      fill_table(n);
      while (beat_count - start < PHASE_BEATS) begin
        // occasional stray load scrambles the ordering
        if ($urandom_range(0, 99) < 8)
          load_point($urandom_range(0, TABLE_DEPTH - 1), $urandom, $urandom);
        else
          random_query(n);
      end
    end
    calm = 1'b0;
  endtask

  initial begin
    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    in_data    <= '0;
    cfg_we     <= 1'b0;
    cfg_wdata  <= '0;
    points_cfg  = 1;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_single_breakpoint();
    test_zero_width();
    test_segment_search();
    test_unsorted_table();
    test_random_tables();
    wait_idle();

    $display("Covered %0d input beats: %0d breakpoint loads and %0d queries.",
             beat_count, load_count, query_count);
    $display("Checked %0d result beats, %0d of them clipped; %0d mismatches.",
             checked_count, sat_count, error_count);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
